/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define IEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iem: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define IEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iem: next-cycle check failed");

`endif

/* src/iem_pkg.sv */
package iem_pkg;

    typedef enum logic [3:0] {
        OP_END,
        OP_START,
        OP_STOP,
        OP_WDEVW,
        OP_WDEVR,
        OP_WADDR,
        OP_WZERO,
        OP_WDATA,
        OP_RBYTES,
        OP_WAIT
    } t_op;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_PROBE,
        CMD_WRITE,
        CMD_READ
    } t_cmd;

    localparam logic [6:0]  DEV_ADDR_RST    = 7'd80;
    localparam logic [15:0] WAIT_TICKS_RST  = 16'd1200;
    // step of the stop in the byte-write sequence (a NACK jumps here)
    localparam logic [3:0]  WRITE_STOP_STEP = 4'd5;
    localparam int          PADDR_W         = 3;

    // register index, taken from address bit 2
    localparam logic        REG_DEV_ADDR    = 1'b0;
    localparam logic        REG_WAIT_TICKS  = 1'b1;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic [8:0] read_count;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
        logic       nack;
    } t_result;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] write_wait_ticks;
    } t_cfg;

    // Sequence program: steps from 1 (up to 7 for a read) of each transaction kind, step 0 is idle.
    function automatic t_op step_op(t_cmd kind, logic [3:0] step);
        t_op op;
        op = OP_END;
        case (kind)
            CMD_PROBE: begin
                case (step)
                    4'd1:    op = OP_START;
                    4'd2:    op = OP_WDEVW;
                    4'd3:    op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            CMD_WRITE: begin
                case (step)
                    4'd1:    op = OP_START;
                    4'd2:    op = OP_WDEVW;
                    4'd3:    op = OP_WADDR;
                    4'd4:    op = OP_WDATA;
                    4'd5:    op = OP_STOP;
                    4'd6:    op = OP_WAIT;
                    default: op = OP_END;
                endcase
            end
            CMD_READ: begin
                case (step)
                    4'd1:    op = OP_START;
                    4'd2:    op = OP_WDEVW;
                    4'd3:    op = OP_WZERO;
                    4'd4:    op = OP_START;
                    4'd5:    op = OP_WDEVR;
                    4'd6:    op = OP_RBYTES;
                    4'd7:    op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            default: op = OP_END;
        endcase
        return op;
    endfunction

endpackage

/* src/iem_seq.sv */
module iem_seq #(
    parameter int MAX_READ = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  iem_pkg::t_item   i_item,
    input  iem_pkg::t_cfg    i_cfg,
    output iem_pkg::t_result o_result
);
    import iem_pkg::*;

    localparam int CNT_W = $clog2(MAX_READ + 1);

    logic [3:0]       r_step, n_step;
    logic [1:0]       r_sub, n_sub;
    logic [3:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic [CNT_W-1:0] r_left, n_left;
    t_cmd             r_kind, n_kind;
    logic [15:0]      r_wait, n_wait;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_data, n_data;
    logic             r_nack, n_nack;

    t_op        op, op1, op2;
    logic [3:0] s1, s2;
    logic [7:0] tx_byte;
    logic       adv, done;
    t_result    res;

    always_comb begin
        n_step  = r_step;
        n_sub   = r_sub;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_left  = r_left;
        n_kind  = r_kind;
        n_wait  = r_wait;
        n_addr  = r_addr;
        n_data  = r_data;
        n_nack  = r_nack;
        res         = '0;
        res.scl_out = 1'b1;
        res.sda_out = 1'b1;
        op      = OP_END;
        op1     = OP_END;
        op2     = OP_END;
        s1      = '0;
        s2      = '0;
        tx_byte = '0;
        adv     = 1'b0;
        done    = 1'b0;

        if (r_step == 4'd0 && i_item.command != CMD_TICK) begin
            n_kind  = i_item.command;
            n_addr  = i_item.mem_address;
            n_data  = i_item.write_data;
            if (i_item.read_count == 9'd0) begin
                n_left = CNT_W'(1);
            end else if (int'(i_item.read_count) > MAX_READ) begin
                n_left = CNT_W'(MAX_READ);
            end else begin
                n_left = CNT_W'(i_item.read_count);
            end
            n_nack  = 1'b0;
            n_shift = '0;
            n_bit   = '0;
            n_sub   = '0;
            n_wait  = '0;
            n_step  = 4'd1;
        end

        if (n_step != 4'd0) begin
            op = step_op(n_kind, n_step);
            res.busy_res = 1'b1;
            case (op)
                OP_START: begin
                    res.scl_out = (n_sub != 2'd2);
                    res.sda_out = (n_sub == 2'd0);
                    if (n_sub >= 2'd2) adv = 1'b1;
                    else n_sub = n_sub + 2'd1;
                end
                OP_STOP: begin
                    res.scl_out = (n_sub != 2'd0);
                    res.sda_out = (n_sub >= 2'd2);
                    if (n_sub >= 2'd2) adv = 1'b1;
                    else n_sub = n_sub + 2'd1;
                end
                OP_WDEVW, OP_WDEVR, OP_WADDR, OP_WZERO, OP_WDATA: begin
                    case (op)
                        OP_WDEVW: tx_byte = {i_cfg.device_address, 1'b0};
                        OP_WDEVR: tx_byte = {i_cfg.device_address, 1'b1};
                        OP_WADDR: tx_byte = n_addr;
                        OP_WDATA: tx_byte = n_data;
                        default:  tx_byte = '0;
                    endcase
                    res.scl_out = (n_sub == 2'd1);
                    if (n_bit < 4'd8) begin
                        res.sda_out = tx_byte[~n_bit[2:0]];
                        if (n_sub >= 2'd2) begin
                            n_sub = '0;
                            n_bit = n_bit + 4'd1;
                        end else begin
                            n_sub = n_sub + 2'd1;
                        end
                    end else begin
                        // acknowledge slot from the slave
                        res.sda_out = 1'b1;
                        if (n_sub >= 2'd2) begin
                            if (i_item.sda_in) begin
                                n_nack = 1'b1;
                                if (n_kind == CMD_WRITE) begin
                                    n_step = WRITE_STOP_STEP;
                                    n_bit  = '0;
                                    n_sub  = '0;
                                end else begin
                                    adv = 1'b1;
                                end
                            end else begin
                                adv = 1'b1;
                            end
                        end else begin
                            n_sub = n_sub + 2'd1;
                        end
                    end
                end
                OP_RBYTES: begin
                    res.scl_out = (n_sub == 2'd1);
                    if (n_bit < 4'd8) begin
                        res.sda_out = 1'b1;
                        if (n_sub >= 2'd2) begin
                            n_shift = {n_shift[6:0], i_item.sda_in};
                            if (n_bit == 4'd7) begin
                                res.read_valid = 1'b1;
                                res.read_data  = n_shift;
                                res.read_last  = (n_left <= CNT_W'(1));
                            end
                            n_bit = n_bit + 4'd1;
                            n_sub = '0;
                        end else begin
                            n_sub = n_sub + 2'd1;
                        end
                    end else begin
                        // master ACK while more bytes follow
                        res.sda_out = !(n_left > CNT_W'(1));
                        if (n_sub >= 2'd2) begin
                            if (n_left != '0) n_left = n_left - CNT_W'(1);
                            if (n_left == '0) begin
                                adv = 1'b1;
                            end else begin
                                n_bit = '0;
                                n_sub = '0;
                            end
                        end else begin
                            n_sub = n_sub + 2'd1;
                        end
                    end
                end
                OP_WAIT: begin
                    if (n_wait != 16'd0) n_wait = n_wait - 16'd1;
                    if (n_wait == 16'd0) adv = 1'b1;
                end
                default: begin
                    n_step = '0;
                    done   = 1'b1;
                end
            endcase

            if (adv) begin
                n_bit = '0;
                n_sub = '0;
                s1  = n_step + 4'd1;
                op1 = step_op(n_kind, s1);
                if (op1 == OP_WAIT) begin
                    if (n_nack || i_cfg.write_wait_ticks == 16'd0) begin
                        s2  = s1 + 4'd1;
                        op2 = step_op(n_kind, s2);
                        if (op2 == OP_END) begin
                            n_step = '0;
                            done   = 1'b1;
                        end else begin
                            n_step = s2;
                        end
                    end else begin
                        n_step = s1;
                        n_wait = i_cfg.write_wait_ticks;
                    end
                end else if (op1 == OP_END) begin
                    n_step = '0;
                    done   = 1'b1;
                end else begin
                    n_step = s1;
                end
            end

            res.done_res = done;
            res.nack     = done & n_nack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_sub  <= '0;
            r_bit  <= '0;
            r_left <= '0;
            r_kind <= CMD_TICK;
            r_wait <= '0;
            r_nack <= 1'b0;
        end else if (i_step) begin
            r_step <= n_step;
            r_sub  <= n_sub;
            r_bit  <= n_bit;
            r_left <= n_left;
            r_kind <= n_kind;
            r_wait <= n_wait;
            r_nack <= n_nack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_shift <= n_shift;
            r_addr  <= n_addr;
            r_data  <= n_data;
        end
    end

    assign o_result = res;

endmodule

/* src/i2c_eeprom_master.sv */
// I2C master for a 24LC-style EEPROM, stepped one bus phase per input transfer.
// Input stream: tuser carries the command (tick, probe, byte write, sequential
// read), tdata the address, data byte, read count and the SDA level sampled in
// the previous phase. A command is only taken while the sequencer is idle.
// Output stream: one result per input transfer with the SCL/SDA drive levels
// (1 = release), busy, read byte strobe and data, done and NACK; tlast marks
// the last byte of a sequential read.
// The result is registered, out in the cycle after its input transfer; a transfer
// can be taken every cycle unless stalled, sequencer state and result updating together.
// A finished result waits in the output register; while the receiver stalls
// with a result held, s_tready drops, and it rises again in the cycle the
// result is taken, so a new item enters as the old one leaves.
// Reset (synchronous, active low) returns the sequencer to idle, empties the
// output register and loads the device address (80) and write wait (1200).
// Registers on the APB port: device address at 0x0, write wait ticks at 0x4;
// write them only while the block is idle.
module i2c_eeprom_master #(
    parameter int MAX_READ = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,  // mem_address, write_data, read_count, sda_in
    input  logic [1:0]                  s_tuser,  // command
    // master side
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,  // scl_out, sda_out, busy_res, read_valid,
                                                  // read_data, done_res, nack
    output logic                        m_tlast,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iem_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import iem_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_result seq_res;
    t_result r_out;
    logic    r_out_valid;
    logic    step;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address   <= DEV_ADDR_RST;
            r_cfg.write_wait_ticks <= WAIT_TICKS_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_DEV_ADDR:   r_cfg.device_address   <= pwdata[6:0];
                REG_WAIT_TICKS: r_cfg.write_wait_ticks <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DEV_ADDR:   prdata = {25'd0, r_cfg.device_address};
            REG_WAIT_TICKS: prdata = {16'd0, r_cfg.write_wait_ticks};
            default:        prdata = '0;
        endcase
    end

    assign item.command     = t_cmd'(s_tuser);
    assign item.mem_address = s_tdata[7:0];
    assign item.write_data  = s_tdata[15:8];
    assign item.read_count  = s_tdata[24:16];
    assign item.sda_in      = s_tdata[25];

    assign s_tready = !r_out_valid || m_tready;
    assign step     = s_tvalid && s_tready;

    iem_seq #(
        .MAX_READ (MAX_READ)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_tready) begin
            r_out_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= seq_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_out.read_last;
    assign m_tdata  = {2'b00, r_out.nack, r_out.done_res, r_out.read_data,
                       r_out.read_valid, r_out.busy_res, r_out.sda_out, r_out.scl_out};

endmodule

/* src/iem_checker.sv */
`include "assert_macros.svh"

module iem_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // no read byte: data and last stay clear
    `IEM_ASSERT_NOW(a_read_fields_clear, i_clk, i_rst_n, m_tvalid && !m_tdata[3], m_tdata[11:4] == 8'd0 && !m_tlast)

    // NACK is only flagged together with done
    `IEM_ASSERT_NOW(a_nack_with_done, i_clk, i_rst_n, m_tvalid && m_tdata[13], m_tdata[12])

    // an idle tick releases both lines and finishes nothing
    `IEM_ASSERT_NOW(a_idle_release, i_clk, i_rst_n, m_tvalid && !m_tdata[2], m_tdata[1:0] == 2'b11 && !m_tdata[12] && !m_tdata[3])

    // a stalled result holds
    `IEM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind i2c_eeprom_master iem_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
